// ===== rtl/nps_pkg.sv =====
// nps_pkg: shared widths, codes, reset values and control structs for the
// nearest point search block; no dependencies
`timescale 1ns / 1ps

package nps_pkg;

  localparam int COORD_W    = 24;
  localparam int THR_W      = 24;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = 50;
  localparam int INDEX_W    = 10;
  localparam int STATUS_W   = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 50;

  localparam int MAX_POINTS_DEF = 1024;

  // 0.00001 in Q0.24 and 1.1^2 in Q2.48
  localparam logic [THR_W-1:0]  DUP_THR_RST = 24'd168;
  localparam logic [DIST_W-1:0] BOUND_RST   = 50'd340584721819893;

  // commands of an input word
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // status codes of a result word
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STS_STORED  = 3'd0;
  localparam status_t STS_DUP     = 3'd1;
  localparam status_t STS_FULL    = 3'd2;
  localparam status_t STS_QUERY   = 3'd3;
  localparam status_t STS_CLEARED = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND   = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic    start;
    logic    rd_en;
    logic    commit;
    logic    store;
    status_t status;
  } nps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic dup_hit;
    logic out_free;
  } nps_stat_t;

endpackage

// ===== rtl/nps_req_if.sv =====
// nps_req_if: input channel of the nearest point search block
// depends on nps_pkg
`timescale 1ns / 1ps

interface nps_req_if import nps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;

  modport source (output valid, output command, output point_x, output point_y,
                  input ready);
  modport sink (input valid, input command, input point_x, input point_y,
                output ready);
endinterface

// ===== rtl/nps_rsp_if.sv =====
// nps_rsp_if: result channel of the nearest point search block
// depends on nps_pkg
`timescale 1ns / 1ps

interface nps_rsp_if import nps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATUS_W-1:0] status;
  logic               found;
  logic [INDEX_W-1:0] point_index;
  logic [DIST_W-1:0]  distance_sq;

  modport source (output valid, output status, output found, output point_index,
                  output distance_sq, input ready);
  modport sink (input valid, input status, input found, input point_index,
                input distance_sq, output ready);
endinterface

// ===== rtl/nps_ram.sv =====
// nps_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module nps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/nps_ctrl.sv =====
// nps_ctrl: sequencer of the nearest point search block; owns the point count
// and the scan address; depends on nps_pkg
`timescale 1ns / 1ps

module nps_ctrl import nps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  output nps_cmd_t         cmd,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] wr_addr,
  input  nps_stat_t        stat
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CMD_W-1:0] op, op_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] addr, addr_next;
  logic             full;

  assign full     = (count == CNT_W'(MAX_POINTS));
  assign rd_addr  = addr;
  assign wr_addr  = count[IDX_W-1:0];
  assign in_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next = state;
    op_next    = op;
    count_next = count;
    addr_next  = addr;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_next = in_command;
          case (in_command)
            CMD_LOAD, CMD_QUERY: begin
              cmd.start  = 1'b1;
              addr_next  = '0;
              state_next = (count == '0) ? ST_DRAIN : ST_SCAN;
            end
            CMD_CLEAR: begin
              state_next = ST_DONE;
            end
            default: ;  // unused command, dropped
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        addr_next = addr + IDX_W'(1);
        if (CNT_W'(addr) == count - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
          case (op)
            CMD_CLEAR: begin
              cmd.status = STS_CLEARED;
              count_next = '0;
            end
            CMD_QUERY: begin
              cmd.status = STS_QUERY;
            end
            default: begin
              if (stat.dup_hit) begin
                cmd.status = STS_DUP;
              end else if (full) begin
                cmd.status = STS_FULL;
              end else begin
                cmd.status = STS_STORED;
                cmd.store  = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      addr  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      addr  <= addr_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count above table depth");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !full)
    else $error("store into a full table");

  a_drain_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && !stat.busy) |=> (state == ST_DONE))
    else $error("drain did not finish once pipeline emptied");

endmodule

// ===== rtl/nps_dp.sv =====
// nps_dp: point table, distance pipeline, best and duplicate trackers and
// result register; depends on nps_pkg, nps_ram, nps_rsp_if
`timescale 1ns / 1ps

module nps_dp import nps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  nps_cmd_t           cmd,
  input  logic [IDX_W-1:0]   rd_addr,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [COORD_W-1:0] point_x,
  input  logic [COORD_W-1:0] point_y,
  input  logic [THR_W-1:0]   dup_threshold,
  input  logic [DIST_W-1:0]  search_bound_sq,
  output nps_stat_t          stat,
  nps_rsp_if.source          rsp
);

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [INDEX_W-1:0] fit_index(input logic [IDX_W-1:0] i);
    logic [IDX_W+INDEX_W-1:0] w;
    w = {{INDEX_W{1'b0}}, i};
    return w[INDEX_W-1:0];
  endfunction

  logic [COORD_W-1:0]   qx, qy;
  logic [2*COORD_W-1:0] rd_data;
  logic [COORD_W-1:0]   rd_x, rd_y;

  // pipeline: ram read, abs diff, squares, sum, compare
  logic               v1, v2, v3, v4;
  logic [IDX_W-1:0]   idx1, idx2, idx3, idx4;
  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]    sqx, sqy;
  logic [DIST_W-1:0]  sum;

  logic [DIST_W-1:0]  best;
  logic [IDX_W-1:0]   best_idx;
  logic               hit;
  logic               dup_hit;
  logic [IDX_W-1:0]   dup_idx;

  logic                out_valid;
  status_t             out_status;
  logic                out_found;
  logic [INDEX_W-1:0]  out_index;
  logic [DIST_W-1:0]   out_dist;

  nps_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wr_addr),
    .wdata ({qx, qy}),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_x = rd_data[2*COORD_W-1:COORD_W];
  assign rd_y = rd_data[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx <= point_x;
      qy <= point_y;
    end
    idx1 <= rd_addr;
    dx   <= abs_diff(rd_x, qx);
    dy   <= abs_diff(rd_y, qy);
    idx2 <= idx1;
    sqx  <= dx * dx;
    sqy  <= dy * dy;
    idx3 <= idx2;
    sum  <= DIST_W'(sqx) + DIST_W'(sqy);
    idx4 <= idx3;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // first stored point within the threshold on both axes
  always_ff @(posedge clk) begin
    if (rst) begin
      dup_hit <= 1'b0;
    end else if (cmd.start) begin
      dup_hit <= 1'b0;
    end else if (v2 && !dup_hit && dx <= dup_threshold && dy <= dup_threshold) begin
      dup_hit <= 1'b1;
      dup_idx <= idx2;
    end
  end

  // strict compare keeps the first of equal distances
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.start) begin
      hit  <= 1'b0;
      best <= search_bound_sq;
    end else if (v4 && sum < best) begin
      hit      <= 1'b1;
      best     <= sum;
      best_idx <= idx4;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= cmd.status;
      out_found  <= (cmd.status == STS_QUERY) && hit;
      out_dist   <= ((cmd.status == STS_QUERY) && hit) ? best : '0;
      case (cmd.status)
        STS_QUERY:  out_index <= hit ? fit_index(best_idx) : '0;
        STS_DUP:    out_index <= fit_index(dup_idx);
        STS_STORED: out_index <= fit_index(wr_addr);
        default:    out_index <= '0;
      endcase
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found       = out_found;
  assign rsp.point_index = out_index;
  assign rsp.distance_sq = out_dist;

  assign stat.busy     = v1 | v2 | v3 | v4;
  assign stat.dup_hit  = dup_hit;
  assign stat.out_free = !out_valid || rsp.ready;

  a_commit_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(v1 || v2 || v3 || v4))
    else $error("result committed with scan still in flight");

  a_commit_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule

// ===== rtl/nearest_point_search_top.sv =====
// nearest_point_search_top: top level of the nearest point search block
// depends on nps_pkg, nps_req_if, nps_rsp_if, nps_ctrl, nps_dp, nps_ram
`timescale 1ns / 1ps

// usage
//   req channel: one word per item; command load, query or clear plus a point
//   in unsigned q0.24. command three is taken and dropped without a result.
//   rsp channel: one word per load, query or clear, in input order.
//   cfg port: cfg_we with cfg_index 0 writes the duplicate threshold, index 1
//   the squared search bound; other indexes are ignored. write only when idle.
// sequence
//   load and query scan the n stored points one per cycle through the table
//   ram read port and a five stage distance pipeline, n up to MAX_POINTS; the
//   result is registered once the pipeline has drained and the result register
//   is free, and the scan is skipped with an empty table. clear skips scan and
//   drain. one item is in work at a time; req.ready rises together with
//   rsp.valid.
// reset
//   synchronous rst empties the table and restores both config registers;
//   table contents are not cleared, the count alone marks valid entries.
// stalls
//   the result register holds its word while rsp.ready is low; the next item
//   may be taken meanwhile and its result waits until the register frees up.

module nearest_point_search_top import nps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  nps_req_if.sink               req,
  nps_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  // configuration registers
  logic [THR_W-1:0]  dup_threshold;
  logic [DIST_W-1:0] search_bound_sq;

  // controller <-> datapath
  nps_cmd_t         cmd;
  nps_stat_t        stat;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dup_threshold   <= DUP_THR_RST;
      search_bound_sq <= BOUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DUP_THR: dup_threshold   <= cfg_data[THR_W-1:0];
        CFG_BOUND:   search_bound_sq <= cfg_data[DIST_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign req.ready = in_ready;

  // sequencer: accepts words, steps the scan, commits results
  nps_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .stat       (stat)
  );

  // table, distance pipeline and result register
  nps_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .wr_addr         (wr_addr),
    .point_x         (req.point_x),
    .point_y         (req.point_y),
    .dup_threshold   (dup_threshold),
    .search_bound_sq (search_bound_sq),
    .stat            (stat),
    .rsp             (rsp)
  );

endmodule

// ===== tb/nps_checker.sv =====
// nps_checker: watches the request, result and config ports of the nearest point
// search block, predicts every result word and compares it field by field
// depends on nps_pkg, nps_req_if, nps_rsp_if
`timescale 1ns / 1ps

module nps_checker import nps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  nps_req_if                    req,
  nps_rsp_if                    rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [INDEX_W-1:0] point_index;
    logic [DIST_W-1:0]  distance_sq;
  } answer_t;

  answer_t            answers_due[$];
  logic [COORD_W-1:0] table_x [MAX_POINTS];
  logic [COORD_W-1:0] table_y [MAX_POINTS];
  int unsigned        point_count;
  logic [THR_W-1:0]   dup_thr;
  logic [DIST_W-1:0]  bound_sq;

  function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // applies one word to the point table and returns 1 if it causes a result
  function automatic bit apply_word(input logic [CMD_W-1:0] cmd,
                                    input logic [COORD_W-1:0] qx,
                                    input logic [COORD_W-1:0] qy,
                                    output answer_t ans);
    logic [DIST_W-1:0] dxw;
    logic [DIST_W-1:0] dyw;
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] best;
    ans = '0;
    case (cmd)
      CMD_LOAD: begin
        for (int unsigned i = 0; i < point_count; i++) begin
          if (span(table_x[i], qx) <= dup_thr && span(table_y[i], qy) <= dup_thr) begin
            ans.status      = STS_DUP;
            ans.point_index = INDEX_W'(i);
            return 1'b1;
          end
        end
        if (point_count >= MAX_POINTS) begin
          ans.status = STS_FULL;
          return 1'b1;
        end
        table_x[point_count] = qx;
        table_y[point_count] = qy;
        ans.status           = STS_STORED;
        ans.point_index      = INDEX_W'(point_count);
        point_count++;
        return 1'b1;
      end
      CMD_QUERY: begin
        best       = bound_sq;
        ans.status = STS_QUERY;
        for (int unsigned i = 0; i < point_count; i++) begin
          dxw = DIST_W'(span(table_x[i], qx));
          dyw = DIST_W'(span(table_y[i], qy));
          d   = dxw * dxw + dyw * dyw;
          if (d < best) begin
            best            = d;
            ans.found       = 1'b1;
            ans.point_index = INDEX_W'(i);
            ans.distance_sq = d;
          end
        end
        return 1'b1;
      end
      CMD_CLEAR: begin
        point_count = 0;
        ans.status  = STS_CLEARED;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    answer_t fresh;
    answer_t due;
    if (rst) begin
      point_count = 0;
      dup_thr     = DUP_THR_RST;
      bound_sq    = BOUND_RST;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DUP_THR: dup_thr = cfg_data[THR_W-1:0];
          CFG_BOUND:   bound_sq = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result word with none expected, status %0d index %0d",
                   $time, rsp.status, rsp.point_index);
          mismatches++;
        end else begin
          due = answers_due.pop_front();
          check_field("status", 64'(due.status), 64'(rsp.status));
          check_field("found", 64'(due.found), 64'(rsp.found));
          check_field("point_index", 64'(due.point_index), 64'(rsp.point_index));
          check_field("distance_sq", 64'(due.distance_sq), 64'(rsp.distance_sq));
        end
      end
      if (req.valid && req.ready) begin
        if (apply_word(req.command, req.point_x, req.point_y, fresh))
          answers_due = {answers_due, fresh};
      end
    end
    pending <= answers_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: regression for nearest_point_search_top, directed and random words
// under several idle patterns and config settings; the checker gives the verdict data
// depends on nps_pkg, nps_req_if, nps_rsp_if, nps_checker, nearest_point_search_top
`timescale 1ns / 1ps

module tb_top;
  import nps_pkg::*;

  localparam int TABLE_DEPTH  = MAX_POINTS_DEF;
  // longest scan plus pipeline, waited out before a config write
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int PHASE_ITEMS  = 93;
  localparam int PHASES       = 6;

  // command three is taken and dropped by the block
  localparam logic [CMD_W-1:0]     CMD_IGNORED = 2'd3;
  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD_2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD_3  = 2'd3;
  localparam logic [DIST_W-1:0]    BOUND_MAX   = 50'd562949953421312;
  localparam logic [COORD_W-1:0]   COORD_MAX   = '1;
  localparam logic [COORD_W-1:0]   COORD_HALF  = 24'h800000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  rsp_take  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int               send_idle  = 0;
  int               recv_stall = 0;
  int               mismatches;
  int               pending;
  int               cycles     = 0;
  logic [THR_W-1:0] cur_thr    = DUP_THR_RST;
  // points loaded since the last clear, used to aim new words near them
  point_t           recent[$];

  nps_req_if req_if ();
  nps_rsp_if rsp_if ();

  assign rsp_if.ready = rsp_take;

  nearest_point_search_top #(.MAX_POINTS(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nps_checker #(.MAX_POINTS(TABLE_DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stalls at random, rate set per phase
  always @(posedge clk) begin
    rsp_take <= ($urandom_range(99) >= recv_stall);
  end

  // one word per call; returns at the edge that takes it, valid left high
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y);
    point_t p;
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.point_x <= x;
    req_if.point_y <= y;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    p.x = x;
    p.y = y;
    if (cmd == CMD_LOAD && recent.size() < 2 * TABLE_DEPTH) recent = {recent, p};
    if (cmd == CMD_CLEAR) recent.delete();
  endtask

  // sender pauses until every expected result word has arrived
  task automatic hold_until_empty();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // block fully idle: also covers a dropped word still in flight
  task automatic quiesce();
    hold_until_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // junk in the upper data bits must be dropped by the 24 bit register
  task automatic set_thr(input logic [THR_W-1:0] thr);
    cfg_write(CFG_DUP_THR, {(CFG_DATA_W - THR_W)'($urandom), thr});
    cur_thr = thr;
  endtask

  task automatic set_idle(input int s, input int r);
    send_idle  = s;
    recv_stall = r;
  endtask

  // offset around a threshold: on it, just past it, inside it or anywhere
  function automatic logic [COORD_W-1:0] near_offset(input logic [COORD_W-1:0] thr);
    logic [COORD_W-1:0] off;
    case ($urandom_range(5))
      0:       off = '0;
      1:       off = thr;
      2:       off = thr + COORD_W'(1);
      3:       off = COORD_W'($urandom_range(255));
      4:       off = COORD_W'($urandom_range(thr));
      default: off = COORD_W'($urandom);
    endcase
    return $urandom_range(1) ? -off : off;
  endfunction

  // one random word; counted is 0 for a word the block only drops
  task automatic random_item(output bit counted);
    int                 r;
    point_t             base;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    r       = $urandom_range(99);
    x       = COORD_W'($urandom);
    y       = COORD_W'($urandom);
    base    = '0;
    counted = 1'b1;
    if (recent.size() != 0) base = recent[$urandom_range(recent.size() - 1)];
    if (r < 4) begin
      send_word(CMD_CLEAR, x, y);
    end else if (r < 7) begin
      send_word(CMD_IGNORED, x, y);
      counted = 1'b0;
    end else if (r < 52) begin
      // loads mostly land near a stored point to hit the duplicate edge
      if (recent.size() != 0 && $urandom_range(9) < 6) begin
        x = base.x + near_offset(cur_thr);
        y = base.y + near_offset(cur_thr);
      end
      send_word(CMD_LOAD, x, y);
    end else begin
      if (recent.size() != 0 && $urandom_range(1)) begin
        x = base.x + near_offset(COORD_W'(4095));
        y = base.y + near_offset(COORD_W'(4095));
      end else if ($urandom_range(9) == 0) begin
        x = $urandom_range(1) ? '0 : COORD_MAX;
        y = $urandom_range(1) ? '0 : COORD_MAX;
      end
      send_word(CMD_QUERY, x, y);
    end
  endtask

  // watchdog
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("nearest_point_search_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int                count;
    bit                took;
    logic [DIST_W-1:0] bound;
    req_if.valid   = 1'b0;
    req_if.command = CMD_LOAD;
    req_if.point_x = '0;
    req_if.point_y = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset config
    send_word(CMD_QUERY, '0, '0);                     // empty table, nothing found
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_LOAD, '0, '0);                      // slot 0
    send_word(CMD_LOAD, COORD_MAX, COORD_MAX);        // slot 1
    send_word(CMD_LOAD, 24'd168, 24'd168);            // exactly on threshold: duplicate of 0
    send_word(CMD_LOAD, 24'd169, '0);                 // one past threshold: stored
    send_word(CMD_LOAD, COORD_MAX - 24'd168, COORD_MAX); // duplicate of 1
    send_word(CMD_IGNORED, 24'h123456, 24'h654321);   // dropped, no result
    send_word(CMD_QUERY, COORD_MAX, '0);
    send_word(CMD_QUERY, '0, '0);                     // zero distance
    send_word(CMD_QUERY, COORD_MAX, COORD_MAX);
    send_word(CMD_LOAD, 24'h400000, COORD_HALF);
    send_word(CMD_LOAD, 24'hC00000, COORD_HALF);
    send_word(CMD_QUERY, COORD_HALF, COORD_HALF);     // tie, lower index wins

    // distance equal to the bound must not qualify, one below must
    quiesce();
    cfg_write(CFG_BOUND, DIST_W'(64'd1 << 44));
    send_word(CMD_QUERY, COORD_HALF, COORD_HALF);
    quiesce();
    cfg_write(CFG_BOUND, DIST_W'((64'd1 << 44) + 1));
    send_word(CMD_QUERY, COORD_HALF, COORD_HALF);
    quiesce();
    cfg_write(CFG_BOUND, '0);                         // nothing qualifies, even zero
    send_word(CMD_QUERY, '0, '0);
    quiesce();
    cfg_write(CFG_BOUND, BOUND_MAX);                  // everything qualifies
    send_word(CMD_QUERY, '0, COORD_MAX);
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_QUERY, '0, '0);
    send_word(CMD_LOAD, 24'h555555, 24'hAAAAAA);      // slot 0 again after clear

    // fill the table to the last slot with exact-match duplicate test only
    quiesce();
    set_thr('0);
    send_word(CMD_CLEAR, '0, '0);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_word(CMD_LOAD, {INDEX_W'(i), (COORD_W - INDEX_W)'($urandom)}, COORD_W'($urandom));
    send_word(CMD_LOAD, COORD_W'($urandom), COORD_W'($urandom));     // table full
    send_word(CMD_LOAD, recent[500].x, recent[500].y);               // duplicate wins over full
    send_word(CMD_QUERY, recent[TABLE_DEPTH-1].x, recent[TABLE_DEPTH-1].y);
    send_word(CMD_QUERY, COORD_W'($urandom), COORD_W'($urandom));
    send_word(CMD_CLEAR, '0, '0);

    // random phases, each with its own config and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      case (p)
        0: begin
          set_thr(DUP_THR_RST);
          cfg_write(CFG_BOUND, BOUND_RST);
          set_idle(0, 0);
        end
        1: begin
          set_thr('0);
          cfg_write(CFG_BOUND, BOUND_MAX);
          set_idle(85, 0);
        end
        2: begin
          set_thr(COORD_MAX);
          cfg_write(CFG_BOUND, '0);
          set_idle(0, 85);
        end
        3: begin
          set_thr(THR_W'($urandom_range(4096)));
          bound = DIST_W'({$urandom, $urandom});
          bound[DIST_W-1] = 1'b0;
          cfg_write(CFG_BOUND, bound);
          // writes to unused indexes must change nothing
          cfg_write(CFG_RSVD_2, CFG_DATA_W'({$urandom, $urandom}));
          cfg_write(CFG_RSVD_3, CFG_DATA_W'({$urandom, $urandom}));
          set_idle(12, 12);
        end
        4: begin
          set_thr(THR_W'($urandom));
          cfg_write(CFG_BOUND, DIST_W'($urandom_range(32'h3FFF_FFFF)));
          set_idle(0, 85);
        end
        default: begin
          set_thr(THR_W'($urandom_range(1023)));
          cfg_write(CFG_BOUND, BOUND_MAX);
          set_idle(12, 12);
        end
      endcase
      count = 0;
      while (count < PHASE_ITEMS) begin
        random_item(took);
        count += took;
        // one full pause mid-phase with results still draining
        if (p == PHASES - 1 && took && count == PHASE_ITEMS / 2) hold_until_empty();
      end
    end

    quiesce();
    if (mismatches == 0 && pending == 0) begin
      $display("nearest_point_search_top regression: pass");
    end else begin
      $display("nearest_point_search_top regression: fail");
    end
    $finish;
  end

endmodule
